[src/lzss_pkg.sv]
// shared constants for the lzss stream decoder
package lzss_pkg;

	localparam int INDEX_BITS_DEF = 11;
	localparam int LENGTH_BITS_DEF = 4;
	localparam logic [7:0] FILL_CHAR = 8'h20;
	localparam logic [7:0] ZERO_CHAR = 8'h00;

endpackage

[src/lzss_stream_decoder.sv]
// lzss stream decoder: bit-serial token parser, history ring and copy sequencer
// each compressed byte is accepted in idle and then parsed one bit per cycle, except that the
// last bit of a literal waits while the output register is full; a byte that ends a match copies
// len+2 bytes, one ring read and one output transfer per copied byte, before the parse goes on
// after reset and after a restart the ring is filled one entry per cycle, all
// 2^INDEX_BITS entries (2048 by default), with in_ready low
module lzss_stream_decoder #(
	parameter int INDEX_BITS = lzss_pkg::INDEX_BITS_DEF,
	parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	localparam int RING_SIZE = 1 << INDEX_BITS;
	localparam int LOOKAHEAD = (1 << LENGTH_BITS) + 1;
	localparam int MATCH_BITS = INDEX_BITS + LENGTH_BITS;
	localparam int CNT_W = $clog2(MATCH_BITS + 1);
	localparam int LEN_W = LENGTH_BITS + 1;
	localparam logic [INDEX_BITS-1:0] FILL_END = INDEX_BITS'(RING_SIZE - LOOKAHEAD);
	localparam logic [INDEX_BITS-1:0] LAST_ADDR = INDEX_BITS'(RING_SIZE - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BITS,
		ST_COPY
	} state_t;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LIT,
		PH_MATCH
	} phase_t;

	state_t                  state_q;
	phase_t                  phase_q;
	logic [INDEX_BITS-1:0]   clr_addr_q;
	logic [INDEX_BITS-1:0]   wp_q;
	logic [MATCH_BITS-1:0]   tok_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [7:0]              byte_q;
	logic [2:0]              bit_idx_q;
	logic                    copy_ret_q;
	logic [INDEX_BITS-1:0]   rd_addr_q;
	logic [LEN_W-1:0]        rd_cnt_q;
	logic [LEN_W-1:0]        rem_q;
	logic                    rd_pend_q;
	logic                    byp_q;
	logic [7:0]              byp_data_q;
	logic [7:0]              rd_data_q;
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic                    last_q;

	logic [7:0] ring [RING_SIZE];

	logic                  out_free;
	logic                  cur_bit;
	logic [MATCH_BITS-1:0] tok_next;
	logic                  lit_done;
	logic                  match_done;
	logic                  lit_emit;
	logic                  consume;
	logic                  issue;
	logic                  we;
	logic [INDEX_BITS-1:0] wa;
	logic [7:0]            wd;
	logic [7:0]            copy_data;
	logic [7:0]            fill_data;
	logic [LEN_W-1:0]      len_next;

	assign out_free = !out_valid_q || out_ready;
	assign cur_bit = byte_q[7];
	assign tok_next = {tok_q[MATCH_BITS-2:0], cur_bit};
	assign lit_done = (phase_q == PH_LIT) && (cnt_q == CNT_W'(7));
	assign match_done = (phase_q == PH_MATCH) && (cnt_q == CNT_W'(MATCH_BITS - 1));
	assign lit_emit = (state_q == ST_BITS) && lit_done && out_free;
	assign consume = (state_q == ST_COPY) && rd_pend_q && out_free;
	assign issue = (state_q == ST_COPY) && (rd_cnt_q != '0) && (!rd_pend_q || consume);
	assign copy_data = byp_q ? byp_data_q : rd_data_q;
	assign fill_data = (clr_addr_q < FILL_END) ? lzss_pkg::FILL_CHAR : lzss_pkg::ZERO_CHAR;
	assign len_next = LEN_W'(tok_next[LENGTH_BITS-1:0]) + LEN_W'(2);

	always_comb begin
		we = 1'b0;
		wa = wp_q;
		wd = copy_data;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = fill_data;
		end else if (lit_emit) begin
			we = 1'b1;
			wd = tok_next[7:0];
		end else if (consume) begin
			we = 1'b1;
		end
	end

	// history ring
	always_ff @(posedge clk) begin
		if (we) begin
			ring[wa] <= wd;
		end
		if (issue) begin
			rd_data_q <= ring[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_FLAG;
			clr_addr_q <= '0;
			wp_q <= FILL_END;
			tok_q <= '0;
			cnt_q <= '0;
			bit_idx_q <= '0;
			copy_ret_q <= 1'b0;
			rd_cnt_q <= '0;
			rem_q <= '0;
			rd_pend_q <= 1'b0;
			byp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register
			if (lit_emit || consume) begin
				out_valid_q <= 1'b1;
				out_byte_q <= lit_emit ? tok_next[7:0] : copy_data;
				last_q <= lit_emit ? 1'b1 : (rem_q == LEN_W'(1));
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// read bypass for a copy that overlaps its own output
			if (issue) begin
				byp_q <= we && (wa == rd_addr_q);
				byp_data_q <= wd;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + INDEX_BITS'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (mode) begin
							state_q <= ST_CLEAR;
							clr_addr_q <= '0;
							wp_q <= FILL_END;
							phase_q <= PH_FLAG;
							tok_q <= '0;
							cnt_q <= '0;
						end else begin
							state_q <= ST_BITS;
							byte_q <= in_byte;
							bit_idx_q <= '0;
						end
					end
				end
				ST_BITS: begin
					if (!(lit_done && !out_free)) begin
						byte_q <= {byte_q[6:0], 1'b0};
						bit_idx_q <= bit_idx_q + 3'd1;
						if (bit_idx_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
						if (phase_q == PH_FLAG) begin
							phase_q <= cur_bit ? PH_LIT : PH_MATCH;
							tok_q <= '0;
							cnt_q <= '0;
						end else begin
							tok_q <= tok_next;
							cnt_q <= cnt_q + CNT_W'(1);
							if (lit_done) begin
								phase_q <= PH_FLAG;
								wp_q <= wp_q + INDEX_BITS'(1);
							end
							if (match_done) begin
								phase_q <= PH_FLAG;
								rd_addr_q <= tok_next[MATCH_BITS-1:LENGTH_BITS];
								rd_cnt_q <= len_next;
								rem_q <= len_next;
								rd_pend_q <= 1'b0;
								copy_ret_q <= (bit_idx_q != 3'd7);
								state_q <= ST_COPY;
							end
						end
					end
				end
				ST_COPY: begin
					if (issue) begin
						rd_addr_q <= rd_addr_q + INDEX_BITS'(1);
						rd_cnt_q <= rd_cnt_q - LEN_W'(1);
						rd_pend_q <= 1'b1;
					end else if (consume) begin
						rd_pend_q <= 1'b0;
					end
					if (consume) begin
						wp_q <= wp_q + INDEX_BITS'(1);
						rem_q <= rem_q - LEN_W'(1);
						if (rem_q == LEN_W'(1)) begin
							state_q <= copy_ret_q ? ST_BITS : ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last_of_run = last_q;

endmodule
